FILE: src/ptts_pkg.sv
// package for the priority task table scheduler
// shared types, codes, widths and the priority clamp; no dependencies
`default_nettype none
package ptts_pkg;

  localparam int TABLE_DEPTH_DFLT = 16;

  localparam int OP_W     = 3;
  localparam int TIDX_W   = 4;
  localparam int PREQ_W   = 8;
  localparam int DEPTH_W  = 16;
  localparam int STATUS_W = 3;
  localparam int HELD_W   = 5;
  localparam int PRIO_W   = 5;
  localparam int MAXP_W   = 6;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [MAXP_W-1:0]  MAXP_RST     = 6'd8;
  localparam logic [DEPTH_W-1:0] MIN_STACK_RST = 16'd128;
  localparam logic [PREQ_W-1:0]  PRIO_CEIL    = 8'd31;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_PRIO  = 1'd0,
    CFG_MIN_STACK = 1'd1
  } cfg_reg_t;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 3'd0,
    OP_DELETE  = 3'd1,
    OP_SUSPEND = 3'd2,
    OP_RESUME  = 3'd3,
    OP_SWITCH  = 3'd4,
    OP_START   = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 3'd0,
    STATUS_FULL     = 3'd1,
    STATUS_BADPARAM = 3'd2,
    STATUS_NOTASK   = 3'd3,
    STATUS_NORUN    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH,
    ST_RESULT
  } state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_DELETE,
    CELL_SUSPEND,
    CELL_RESUME
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [PRIO_W-1:0]   prio;
  } cmd_t;

  typedef struct packed {
    logic                found;
    logic [PRIO_W-1:0]   prio;
  } cand_t;

  function automatic logic [PRIO_W-1:0] clamp_prio(input logic [PREQ_W-1:0] preq,
                                                   input logic [MAXP_W-1:0] maxp);
    logic [PREQ_W-1:0] levels;
    logic [PREQ_W-1:0] p;
    levels = (maxp == '0) ? PREQ_W'(1) : PREQ_W'(maxp);
    p = (preq >= levels) ? (levels - PREQ_W'(1)) : preq;
    if (p > PRIO_CEIL) begin
      p = PRIO_CEIL;
    end
    return p[PRIO_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: src/ptts_if.sv
// request and result channel interfaces for the task scheduler
// depends on ptts_pkg for field widths
`default_nettype none
interface ptts_in_if;
  logic                             valid;
  logic                             ready;
  logic [ptts_pkg::OP_W-1:0]        operation;
  logic [ptts_pkg::TIDX_W-1:0]      task_index;
  logic [ptts_pkg::PREQ_W-1:0]      priority_req;
  logic [ptts_pkg::DEPTH_W-1:0]     stack_depth;
  logic                             has_code;

  modport source (output valid, operation, task_index, priority_req, stack_depth, has_code,
                  input ready);
  modport sink (input valid, operation, task_index, priority_req, stack_depth, has_code,
                output ready);
endinterface

interface ptts_out_if;
  logic                             valid;
  logic                             ready;
  logic                             ok;
  logic [ptts_pkg::STATUS_W-1:0]    status;
  logic [ptts_pkg::TIDX_W-1:0]      created_index;
  logic                             current_valid;
  logic [ptts_pkg::TIDX_W-1:0]      current_index;
  logic [ptts_pkg::HELD_W-1:0]      tasks_held;

  modport source (output valid, ok, status, created_index, current_valid, current_index,
                  tasks_held, input ready);
  modport sink (input valid, ok, status, created_index, current_valid, current_index,
                tasks_held, output ready);
endinterface
`default_nettype wire

FILE: src/ptts_cell.sv
// one table slot: priority, suspend flag and one stage of the selection chain
// depends on ptts_pkg
`default_nettype none
module ptts_cell #(
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire ptts_pkg::cmd_t          cmd,
  input  wire [IDX_W-1:0]              cmd_index,
  input  wire [CNT_W-1:0]              total,
  input  wire                          pick_highest,
  input  wire [IDX_W-1:0]              my_pos,
  input  wire [ptts_pkg::PRIO_W-1:0]   up_prio,
  input  wire                          up_susp,
  output logic [ptts_pkg::PRIO_W-1:0]  prio_o,
  output logic                         susp_o,
  input  wire ptts_pkg::cand_t         cand_in,
  input  wire [IDX_W-1:0]              pos_in,
  output ptts_pkg::cand_t              cand_o,
  output logic [IDX_W-1:0]             pos_o
);
  import ptts_pkg::*;

  logic [PRIO_W-1:0] prio_r, prio_nxt;
  logic              susp_r, susp_nxt;
  cand_t             cand_r, cand_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic              hit;
  logic              runnable;
  logic              take;

  always_comb begin
    prio_nxt = prio_r;
    susp_nxt = susp_r;
    hit      = (my_pos == cmd_index);
    unique case (cmd.op)
      CELL_HOLD: begin
      end
      CELL_WRITE: begin
        if (hit) begin
          prio_nxt = cmd.prio;
          susp_nxt = 1'b0;
        end
      end
      CELL_DELETE: begin
        if (my_pos >= cmd_index) begin
          prio_nxt = up_prio;
          susp_nxt = up_susp;
        end
      end
      CELL_SUSPEND: begin
        if (hit) begin
          susp_nxt = 1'b1;
        end
      end
      CELL_RESUME: begin
        if (hit) begin
          susp_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // candidate from the lower slots against this slot
  always_comb begin
    runnable = !susp_r && (CNT_W'(my_pos) < total);
    take     = runnable && (!cand_in.found || (pick_highest && (prio_r > cand_in.prio)));
    if (take) begin
      cand_nxt.found = 1'b1;
      cand_nxt.prio  = prio_r;
      pos_nxt        = my_pos;
    end else begin
      cand_nxt = cand_in;
      pos_nxt  = pos_in;
    end
  end

  always_ff @(posedge clk) begin
    prio_r      <= prio_nxt;
    cand_r.prio <= cand_nxt.prio;
    pos_r       <= pos_nxt;
    if (!rst_n) begin
      susp_r       <= 1'b0;
      cand_r.found <= 1'b0;
    end else begin
      susp_r       <= susp_nxt;
      cand_r.found <= cand_nxt.found;
    end
  end

  assign prio_o = prio_r;
  assign susp_o = susp_r;
  assign cand_o = cand_r;
  assign pos_o  = pos_r;

endmodule
`default_nettype wire

FILE: src/priority_task_table_scheduler.sv
// top level of the priority task table scheduler: sequencer plus a row of slot cells
// depends on ptts_pkg, ptts_if (ptts_in_if, ptts_out_if) and ptts_cell
//
//   channel  direction  handshake        content
//   in_if    sink       valid/ready      operation, task_index, priority_req, stack_depth,
//                                        has_code
//   out_if   source     valid/ready      ok, status, created_index, current_valid,
//                                        current_index, tasks_held
//   cfg_*    sink       cfg_we only      cfg_index selects register, cfg_wdata
//
// one request at a time; create, delete, suspend, resume and unknown codes go from the
// execute state to the result state; switch and start first pass the search state, where the
// selection chain passes one slot per cycle; no new request is taken until the result is loaded;
// a finished result waits in the output register while the next request is accepted; a
// result that finds the output register still held waits in place and holds off the input
// synchronous active-low reset empties the table and clears the current task; no clear pass
`default_nettype none
module priority_task_table_scheduler #(
  parameter int TABLE_DEPTH = ptts_pkg::TABLE_DEPTH_DFLT
) (
  input  wire                              clk,
  input  wire                              rst_n,
  ptts_in_if.sink                          in_if,
  ptts_out_if.source                       out_if,
  input  wire                              cfg_we,
  input  wire [ptts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [ptts_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ptts_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > TIDX_W) ? CNT_W : TIDX_W + 1;

  state_t               state_r, state_nxt;
  logic [OP_W-1:0]      req_op_r;
  logic [TIDX_W-1:0]    req_idx_r;
  logic [PREQ_W-1:0]    req_prio_r;
  logic [DEPTH_W-1:0]   req_depth_r;
  logic                 req_code_r;

  logic [MAXP_W-1:0]    maxp_r;
  logic [DEPTH_W-1:0]   min_stack_r;

  logic [CNT_W-1:0]     total_r, total_nxt;
  logic [IDX_W-1:0]     cur_slot_r, cur_slot_nxt;
  logic                 cur_present_r, cur_present_nxt;
  logic                 ok_r, ok_nxt;
  status_t              status_r, status_nxt;
  logic [IDX_W-1:0]     created_r, created_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ok_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [TIDX_W-1:0]    out_created_r;
  logic                 out_cur_valid_r;
  logic [TIDX_W-1:0]    out_cur_index_r;
  logic [HELD_W-1:0]    out_held_r;
  logic                 out_load;

  cmd_t                 cmd;
  logic [IDX_W-1:0]     cmd_index;
  logic                 pick_highest;
  logic                 in_range;
  logic [IDX_W-1:0]     idx_w;

  logic [PRIO_W-1:0]    prio_s [TABLE_DEPTH];
  logic                 susp_s [TABLE_DEPTH];
  cand_t                cand_s [TABLE_DEPTH];
  logic [IDX_W-1:0]     pos_s  [TABLE_DEPTH];

  // slot row
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cand_t                cand_prev;
    logic [IDX_W-1:0]     pos_prev;
    logic [PRIO_W-1:0]    up_prio;
    logic                 up_susp;
    if (i == 0) begin : g_head
      assign cand_prev = '0;
      assign pos_prev  = '0;
    end else begin : g_link
      assign cand_prev = cand_s[i-1];
      assign pos_prev  = pos_s[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign up_prio = '0;
      assign up_susp = 1'b0;
    end else begin : g_up
      assign up_prio = prio_s[i+1];
      assign up_susp = susp_s[i+1];
    end
    ptts_cell #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cmd          (cmd),
      .cmd_index    (cmd_index),
      .total        (total_r),
      .pick_highest (pick_highest),
      .my_pos       (IDX_W'(i)),
      .up_prio      (up_prio),
      .up_susp      (up_susp),
      .prio_o       (prio_s[i]),
      .susp_o       (susp_s[i]),
      .cand_in      (cand_prev),
      .pos_in       (pos_prev),
      .cand_o       (cand_s[i]),
      .pos_o        (pos_s[i])
    );
  end

  assign in_if.ready  = (state_r == ST_IDLE);
  assign pick_highest = (req_op_r == OP_SWITCH);
  assign in_range     = (CMP_W'(req_idx_r) < CMP_W'(total_r));
  assign idx_w        = IDX_W'(req_idx_r);

  always_comb begin
    state_nxt       = state_r;
    total_nxt       = total_r;
    cur_slot_nxt    = cur_slot_r;
    cur_present_nxt = cur_present_r;
    ok_nxt          = ok_r;
    status_nxt      = status_r;
    created_nxt     = created_r;
    cnt_nxt         = cnt_r;
    cmd.op          = CELL_HOLD;
    cmd.prio        = clamp_prio(req_prio_r, maxp_r);
    cmd_index       = idx_w;
    out_load        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ok_nxt      = 1'b0;
        status_nxt  = STATUS_OK;
        created_nxt = '0;
        state_nxt   = ST_RESULT;
        unique case (req_op_r)
          OP_CREATE: begin
            if (total_r == CNT_W'(TABLE_DEPTH)) begin
              status_nxt = STATUS_FULL;
            end else if (!req_code_r || (req_depth_r < min_stack_r)) begin
              status_nxt = STATUS_BADPARAM;
            end else begin
              cmd.op      = CELL_WRITE;
              cmd_index   = IDX_W'(total_r);
              created_nxt = IDX_W'(total_r);
              total_nxt   = total_r + CNT_W'(1);
              ok_nxt      = 1'b1;
            end
          end
          OP_DELETE, OP_SUSPEND, OP_RESUME: begin
            if (!in_range) begin
              status_nxt = STATUS_NOTASK;
            end else begin
              ok_nxt = 1'b1;
              if (req_op_r == OP_SUSPEND) begin
                cmd.op = CELL_SUSPEND;
              end else if (req_op_r == OP_RESUME) begin
                cmd.op = CELL_RESUME;
              end else begin
                cmd.op    = CELL_DELETE;
                total_nxt = total_r - CNT_W'(1);
                if (cur_present_r) begin
                  if (cur_slot_r == idx_w) begin
                    cur_present_nxt = 1'b0;
                  end else if (cur_slot_r > idx_w) begin
                    cur_slot_nxt = cur_slot_r - IDX_W'(1);
                  end
                end
              end
            end
          end
          OP_SWITCH, OP_START: begin
            cnt_nxt   = '0;
            state_nxt = ST_SEARCH;
          end
          default: begin
            status_nxt = STATUS_BADPARAM;
          end
        endcase
      end
      ST_SEARCH: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(TABLE_DEPTH)) begin
          state_nxt = ST_RESULT;
          if (cand_s[TABLE_DEPTH-1].found) begin
            cur_slot_nxt    = pos_s[TABLE_DEPTH-1];
            cur_present_nxt = 1'b1;
            ok_nxt          = 1'b1;
          end else begin
            status_nxt = STATUS_NORUN;
          end
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      total_r       <= '0;
      cur_slot_r    <= '0;
      cur_present_r <= 1'b0;
      ok_r          <= 1'b0;
      status_r      <= STATUS_OK;
      created_r     <= '0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      maxp_r        <= MAXP_RST;
      min_stack_r   <= MIN_STACK_RST;
    end else begin
      state_r       <= state_nxt;
      total_r       <= total_nxt;
      cur_slot_r    <= cur_slot_nxt;
      cur_present_r <= cur_present_nxt;
      ok_r          <= ok_nxt;
      status_r      <= status_nxt;
      created_r     <= created_nxt;
      cnt_r         <= cnt_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_MAX_PRIO:  maxp_r      <= cfg_wdata[MAXP_W-1:0];
          CFG_MIN_STACK: min_stack_r <= cfg_wdata[DEPTH_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      req_op_r    <= in_if.operation;
      req_idx_r   <= in_if.task_index;
      req_prio_r  <= in_if.priority_req;
      req_depth_r <= in_if.stack_depth;
      req_code_r  <= in_if.has_code;
    end
    if (out_load) begin
      out_ok_r        <= ok_r;
      out_status_r    <= status_r;
      out_created_r   <= TIDX_W'(created_r);
      out_cur_valid_r <= cur_present_r;
      out_cur_index_r <= cur_present_r ? TIDX_W'(cur_slot_r) : '0;
      out_held_r      <= HELD_W'(total_r);
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.ok            = out_ok_r;
  assign out_if.status        = out_status_r;
  assign out_if.created_index = out_created_r;
  assign out_if.current_valid = out_cur_valid_r;
  assign out_if.current_index = out_cur_index_r;
  assign out_if.tasks_held    = out_held_r;

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(TABLE_DEPTH))
    else $error("task count beyond table depth");

  a_current_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    cur_present_r |-> (CNT_W'(cur_slot_r) < total_r))
    else $error("current task outside the table");

  a_search_holds_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |=> $stable(total_r))
    else $error("table count changed during selection");

  a_ok_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT) |-> (ok_r == (status_r == STATUS_OK)))
    else $error("ok flag disagrees with status");

endmodule
`default_nettype wire

FILE: tb/priority_task_table_scheduler_tb.sv
// testbench for priority_task_table_scheduler: directed and random task operations,
// checked against an in-bench scheduler predictor through a result queue
// depends on ptts_pkg, ptts_if and the scheduler rtl
module priority_task_table_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptts_pkg::*;

  localparam logic [OP_W-1:0] OP_RESERVED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_RESERVED_HI = 3'd7;
  localparam int SLOTS = TABLE_DEPTH_DFLT;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [TIDX_W-1:0]  tidx;
    logic [PREQ_W-1:0]  preq;
    logic [DEPTH_W-1:0] depth;
    logic               code;
  } sched_req_t;

  typedef struct packed {
    logic                ok;
    logic [STATUS_W-1:0] status;
    logic [TIDX_W-1:0]   created;
    logic                cur_valid;
    logic [TIDX_W-1:0]   cur_idx;
    logic [HELD_W-1:0]   held;
  } sched_resp_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ptts_in_if  req_if ();
  ptts_out_if rsp_if ();

  priority_task_table_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (req_if),
    .out_if    (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // scheduler state as the predictor sees it
  logic [PRIO_W-1:0]  prio_tbl [SLOTS];
  logic               susp_tbl [SLOTS];
  int                 held_cnt;
  int                 cur_slot;
  logic               cur_live;
  logic [MAXP_W-1:0]  prio_levels;
  logic [DEPTH_W-1:0] min_stack;

  sched_resp_t pending_resp_q [$];
  int  err_count;
  bit  src_gaps;
  bit  snk_gaps;
  int  stall_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic sched_resp_t apply_task_op(sched_req_t req);
    sched_resp_t rsp;
    int levels;
    int p;
    int pick;
    int best;
    bit found;
    rsp = '0;
    rsp.status = STATUS_OK;
    case (req.op)
      OP_CREATE: begin
        if (held_cnt >= SLOTS) begin
          rsp.status = STATUS_FULL;
        end else if (!req.code || req.depth < min_stack) begin
          rsp.status = STATUS_BADPARAM;
        end else begin
          levels = (prio_levels == 0) ? 1 : int'(prio_levels);
          p = int'(req.preq);
          if (p >= levels) p = levels - 1;
          if (p > 31) p = 31;
          prio_tbl[held_cnt] = p[PRIO_W-1:0];
          susp_tbl[held_cnt] = 1'b0;
          rsp.created = held_cnt[TIDX_W-1:0];
          held_cnt++;
          rsp.ok = 1'b1;
        end
      end
      OP_DELETE, OP_SUSPEND, OP_RESUME: begin
        if (int'(req.tidx) >= held_cnt) begin
          rsp.status = STATUS_NOTASK;
        end else if (req.op == OP_SUSPEND) begin
          susp_tbl[req.tidx] = 1'b1;
          rsp.ok = 1'b1;
        end else if (req.op == OP_RESUME) begin
          susp_tbl[req.tidx] = 1'b0;
          rsp.ok = 1'b1;
        end else begin
          if (cur_live) begin
            if (cur_slot == int'(req.tidx)) cur_live = 1'b0;
            else if (cur_slot > int'(req.tidx)) cur_slot--;
          end
          for (int i = int'(req.tidx); i + 1 < held_cnt; i++) begin
            prio_tbl[i] = prio_tbl[i + 1];
            susp_tbl[i] = susp_tbl[i + 1];
          end
          prio_tbl[held_cnt - 1] = '0;
          susp_tbl[held_cnt - 1] = 1'b0;
          held_cnt--;
          rsp.ok = 1'b1;
        end
      end
      OP_SWITCH, OP_START: begin
        found = 1'b0;
        pick = 0;
        best = 0;
        for (int i = 0; i < held_cnt; i++) begin
          if (!susp_tbl[i] && !(found && req.op == OP_START) &&
              (!found || int'(prio_tbl[i]) > best)) begin
            found = 1'b1;
            pick = i;
            best = int'(prio_tbl[i]);
          end
        end
        if (found) begin
          cur_slot = pick;
          cur_live = 1'b1;
          rsp.ok = 1'b1;
        end else begin
          rsp.status = STATUS_NORUN;
        end
      end
      default: rsp.status = STATUS_BADPARAM;
    endcase
    rsp.cur_valid = cur_live;
    rsp.cur_idx = cur_live ? cur_slot[TIDX_W-1:0] : '0;
    rsp.held = held_cnt[HELD_W-1:0];
    return rsp;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t: mismatch on %s, expected %0h, got %0h", $time, what, want, got);
    err_count++;
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    sched_resp_t want;
    if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_resp_q.size() == 0) begin
        report_mismatch("unexpected transaction", '0, 32'(rsp_if.status));
      end else begin
        want = pending_resp_q.pop_front();
        if (rsp_if.ok !== want.ok) report_mismatch("ok", 32'(want.ok), 32'(rsp_if.ok));
        if (rsp_if.status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(rsp_if.status));
        if (rsp_if.created_index !== want.created)
          report_mismatch("created_index", 32'(want.created), 32'(rsp_if.created_index));
        if (rsp_if.current_valid !== want.cur_valid)
          report_mismatch("current_valid", 32'(want.cur_valid), 32'(rsp_if.current_valid));
        if (rsp_if.current_index !== want.cur_idx)
          report_mismatch("current_index", 32'(want.cur_idx), 32'(rsp_if.current_index));
        if (rsp_if.tasks_held !== want.held)
          report_mismatch("tasks_held", 32'(want.held), 32'(rsp_if.tasks_held));
      end
    end
  end

  // result receiver with random and long holds
  initial begin : result_sink
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall_cycles) @(posedge clk);
        stall_cycles = 0;
        rsp_if.ready <= 1'b1;
      end else if (snk_gaps && $urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_op(logic [OP_W-1:0] op, logic [TIDX_W-1:0] tidx,
                         logic [PREQ_W-1:0] preq, logic [DEPTH_W-1:0] depth, logic code);
    sched_req_t req;
    req.op = op;
    req.tidx = tidx;
    req.preq = preq;
    req.depth = depth;
    req.code = code;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.operation <= op;
    req_if.task_index <= tidx;
    req_if.priority_req <= preq;
    req_if.stack_depth <= depth;
    req_if.has_code <= code;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    pending_resp_q.push_back(apply_task_op(req));
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (pending_resp_q.size() != 0) @(posedge clk);
    repeat (SLOTS + 4) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == CFG_MAX_PRIO) prio_levels = data[MAXP_W-1:0];
    else min_stack = data;
  endtask

  task automatic run_random_ops(int count);
    int sel;
    logic [OP_W-1:0] op;
    logic [TIDX_W-1:0] tidx;
    logic [PREQ_W-1:0] preq;
    logic [DEPTH_W-1:0] depth;
    logic code;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      tidx = TIDX_W'($urandom_range(0, 15));
      preq = PREQ_W'($urandom);
      depth = DEPTH_W'($urandom);
      code = ($urandom_range(0, 9) != 0);
      if (sel < 30) op = OP_CREATE;
      else if (sel < 50) op = OP_DELETE;
      else if (sel < 62) op = OP_SUSPEND;
      else if (sel < 72) op = OP_RESUME;
      else if (sel < 85) op = OP_SWITCH;
      else if (sel < 97) op = OP_START;
      else op = $urandom_range(0, 1) ? OP_RESERVED_LO : OP_RESERVED_HI;
      if (held_cnt > 0 && $urandom_range(0, 4) != 0)
        tidx = TIDX_W'($urandom_range(0, held_cnt - 1));
      if ($urandom_range(0, 1)) preq = PREQ_W'($urandom_range(0, 40));
      if (op == OP_CREATE && $urandom_range(0, 3) != 0)
        depth = DEPTH_W'($urandom_range(65535, 32'(min_stack)));
      send_op(op, tidx, preq, depth, code);
    end
  endtask

  task automatic test_empty_table();
    send_op(OP_SWITCH, 4'd0, 8'd0, 16'd0, 1'b0);
    send_op(OP_START, 4'd0, 8'd0, 16'd0, 1'b0);
    send_op(OP_DELETE, 4'd0, 8'd0, 16'd0, 1'b0);
    send_op(OP_SUSPEND, 4'd15, 8'd0, 16'd0, 1'b0);
    send_op(OP_RESUME, 4'd0, 8'd0, 16'd0, 1'b0);
    send_op(OP_RESERVED_LO, 4'd0, 8'd0, 16'd0, 1'b1);
    send_op(OP_RESERVED_HI, 4'd15, 8'd255, 16'hFFFF, 1'b1);
  endtask

  task automatic test_create_rules();
    send_op(OP_CREATE, 4'd0, 8'd3, 16'd1000, 1'b0);
    send_op(OP_CREATE, 4'd0, 8'd3, 16'd127, 1'b1);
    send_op(OP_CREATE, 4'd15, 8'd255, 16'hFFFF, 1'b1);
    send_op(OP_CREATE, 4'd0, 8'd0, 16'd128, 1'b1);
    send_op(OP_CREATE, 4'd0, 8'd5, 16'd200, 1'b1);
  endtask

  task automatic test_select_and_delete();
    send_op(OP_SUSPEND, 4'd0, 8'd0, 16'd0, 1'b0);
    send_op(OP_SWITCH, 4'd0, 8'd0, 16'd0, 1'b0);
    send_op(OP_START, 4'd0, 8'd0, 16'd0, 1'b0);
    send_op(OP_RESUME, 4'd0, 8'd0, 16'd0, 1'b0);
    send_op(OP_START, 4'd0, 8'd0, 16'd0, 1'b0);
    // current task removed
    send_op(OP_DELETE, 4'd0, 8'd0, 16'd0, 1'b0);
    send_op(OP_CREATE, 4'd0, 8'd6, 16'd300, 1'b1);
    send_op(OP_SWITCH, 4'd0, 8'd0, 16'd0, 1'b0);
    // entry below current removed, current index moves down
    send_op(OP_DELETE, 4'd0, 8'd0, 16'd0, 1'b0);
    send_op(OP_SUSPEND, 4'd3, 8'd0, 16'd0, 1'b0);
    send_op(OP_DELETE, 4'd15, 8'd0, 16'd0, 1'b0);
    send_op(OP_SUSPEND, 4'd0, 8'd0, 16'd0, 1'b0);
    send_op(OP_SUSPEND, 4'd1, 8'd0, 16'd0, 1'b0);
    send_op(OP_SWITCH, 4'd0, 8'd0, 16'd0, 1'b0);
    send_op(OP_RESUME, 4'd1, 8'd0, 16'd0, 1'b0);
  endtask

  task automatic test_backpressure();
    src_gaps = 1'b0;
    snk_gaps = 1'b0;
    stall_cycles = 300;
    repeat (20)
      send_op(OP_CREATE, TIDX_W'($urandom_range(0, 15)), PREQ_W'($urandom), 16'hFFFF, 1'b1);
    // full table reported ahead of missing code
    send_op(OP_CREATE, 4'd0, 8'd1, 16'd0, 1'b0);
    send_op(OP_SWITCH, 4'd0, 8'd0, 16'd0, 1'b0);
    wait_idle();
  endtask

  task automatic test_config_sweep();
    src_gaps = 1'b1;
    snk_gaps = 1'b1;
    write_cfg(CFG_MAX_PRIO, 16'd32);
    write_cfg(CFG_MIN_STACK, 16'd0);
    run_random_ops(200);
    write_cfg(CFG_MAX_PRIO, 16'd1);
    write_cfg(CFG_MIN_STACK, 16'hFFFF);
    run_random_ops(100);
    write_cfg(CFG_MAX_PRIO, 16'd0);
    write_cfg(CFG_MIN_STACK, 16'd1000);
    run_random_ops(100);
    write_cfg(CFG_MAX_PRIO, 16'd63);
    write_cfg(CFG_MIN_STACK, 16'd128);
    run_random_ops(150);
  endtask

  task automatic test_quiet_tail();
    write_cfg(CFG_MAX_PRIO, 16'd8);
    src_gaps = 1'b0;
    snk_gaps = 1'b0;
    run_random_ops(180);
  endtask

  initial begin
    err_count = 0;
    stall_cycles = 0;
    src_gaps = 1'b1;
    snk_gaps = 1'b1;
    held_cnt = 0;
    cur_slot = 0;
    cur_live = 1'b0;
    prio_levels = MAXP_RST;
    min_stack = MIN_STACK_RST;
    for (int i = 0; i < SLOTS; i++) begin
      prio_tbl[i] = '0;
      susp_tbl[i] = 1'b0;
    end
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_MAX_PRIO;
    cfg_wdata <= '0;
    req_if.valid <= 1'b0;
    req_if.operation <= '0;
    req_if.task_index <= '0;
    req_if.priority_req <= '0;
    req_if.stack_depth <= '0;
    req_if.has_code <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_create_rules();
    test_select_and_delete();
    test_backpressure();
    test_config_sweep();
    test_quiet_tail();
    wait_idle();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/ptts_pkg.sv
src/ptts_if.sv
src/ptts_cell.sv
src/priority_task_table_scheduler.sv
tb/priority_task_table_scheduler_tb.sv
